// ----- design/evkms_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// evkms_pkg
// Shared constants, types and helpers for the event key match selector.
// ----------------------------------------------------------------------------
package evkms_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned FILL_W      = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KEY_W       = 128;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned MATCH_W     = 2;

  localparam logic [MATCH_W-1:0] MATCH_MAX = 2'd3;
  localparam logic [MATCH_W-1:0] MATCH_SEL = 2'd1;
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } evkms_op_e;

  typedef struct packed {
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               key_we;
    logic               cnt_we;
    logic [ADDR_W-1:0]  wr_addr;
    logic [KEY_W-1:0]   wr_key;
    logic [MATCH_W-1:0] wr_cnt;
  } evkms_mem_req_t;

  typedef struct packed {
    logic             selected;
    logic             all_found;
    logic             table_full;
    logic [CNT_W-1:0] processed_count;
  } evkms_res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage
`default_nettype wire

// ----- design/evkms_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// evkms_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module evkms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- design/evkms_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// evkms_ctrl
// Request sequencer: linear table scan, read-modify-write of the match
// count, fill level and the target, selected and query counters.
// ----------------------------------------------------------------------------
module evkms_ctrl import evkms_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_valid_i,
  output logic                    req_ready_o,
  input  wire logic               op_i,
  input  wire logic [KEY_W-1:0]   key_i,
  output evkms_mem_req_t          mem_o,
  input  wire logic [KEY_W-1:0]   key_rdata_i,
  input  wire logic [MATCH_W-1:0] cnt_rdata_i,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output evkms_res_t              res_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]         state_q, state_d;
  logic               op_q, op_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [FILL_W-1:0]  scan_addr_q, scan_addr_d;
  logic               rd_vld_q, rd_vld_d;
  logic [ADDR_W-1:0]  rd_idx_q, rd_idx_d;
  logic               hit_q, hit_d;
  logic [ADDR_W-1:0]  hit_idx_q, hit_idx_d;
  logic [MATCH_W-1:0] hit_cnt_q, hit_cnt_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]   target_q, target_d;
  logic [CNT_W-1:0]   sel_cnt_q, sel_cnt_d;
  logic [CNT_W-1:0]   query_q, query_d;
  logic [KEY_W-1:0]   last_key_q, last_key_d;
  logic               sel_q, sel_d;
  logic               full_q, full_d;

  logic               rd_en;
  logic               key_hit;
  logic               cnt_inc;
  logic [MATCH_W-1:0] new_cnt;

  assign rd_en   = (state_q == S_SCAN) && (scan_addr_q < fill_q);
  assign key_hit = rd_vld_q && (key_rdata_i == key_q);
  assign cnt_inc = (key_q != last_key_q) && (hit_cnt_q != MATCH_MAX);
  assign new_cnt = cnt_inc ? hit_cnt_q + MATCH_W'(1) : hit_cnt_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    scan_addr_d = scan_addr_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = scan_addr_q[ADDR_W-1:0];
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_cnt_d   = hit_cnt_q;
    fill_d      = fill_q;
    target_d    = target_q;
    sel_cnt_d   = sel_cnt_q;
    query_d     = query_q;
    last_key_d  = last_key_q;
    sel_d       = sel_q;
    full_d      = full_q;

    mem_o         = '0;
    mem_o.rd_en   = rd_en;
    mem_o.rd_addr = scan_addr_q[ADDR_W-1:0];
    mem_o.wr_key  = key_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d        = op_i;
          key_d       = key_i;
          scan_addr_d = '0;
          hit_d       = 1'b0;
          state_d     = (fill_q == '0) ? S_UPD : S_SCAN;
        end
      end
      S_SCAN: begin
        rd_vld_d = rd_en;
        if (rd_en) begin
          scan_addr_d = scan_addr_q + FILL_W'(1);
        end
        if (key_hit) begin
          hit_d     = 1'b1;
          hit_idx_d = rd_idx_q;
          hit_cnt_d = cnt_rdata_i;
          rd_vld_d  = 1'b0;
          state_d   = S_UPD;
        end else if (rd_vld_q && !rd_en) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        sel_d  = 1'b0;
        full_d = 1'b0;
        if (op_q == OP_LOAD) begin
          if (hit_q) begin
            mem_o.cnt_we  = 1'b1;
            mem_o.wr_addr = hit_idx_q;
            mem_o.wr_cnt  = '0;
            target_d      = sat_inc(target_q);
          end else if (fill_q != FILL_W'(TABLE_DEPTH)) begin
            mem_o.key_we  = 1'b1;
            mem_o.cnt_we  = 1'b1;
            mem_o.wr_addr = fill_q[ADDR_W-1:0];
            mem_o.wr_cnt  = '0;
            fill_d        = fill_q + FILL_W'(1);
            target_d      = sat_inc(target_q);
          end else begin
            full_d = 1'b1;
          end
        end else begin
          query_d = sat_inc(query_q);
          if (hit_q) begin
            mem_o.cnt_we  = 1'b1;
            mem_o.wr_addr = hit_idx_q;
            mem_o.wr_cnt  = new_cnt;
            last_key_d    = key_q;
            if (new_cnt == MATCH_SEL) begin
              sel_d     = 1'b1;
              sel_cnt_d = sat_inc(sel_cnt_q);
            end
          end
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_addr_q <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      fill_q      <= '0;
      target_q    <= '0;
      sel_cnt_q   <= '0;
      query_q     <= '0;
      last_key_q  <= '0;
      op_q        <= OP_LOAD;
      sel_q       <= 1'b0;
      full_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_addr_q <= scan_addr_d;
      rd_vld_q    <= rd_vld_d;
      hit_q       <= hit_d;
      fill_q      <= fill_d;
      target_q    <= target_d;
      sel_cnt_q   <= sel_cnt_d;
      query_q     <= query_d;
      last_key_q  <= last_key_d;
      op_q        <= op_d;
      sel_q       <= sel_d;
      full_q      <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    rd_idx_q  <= rd_idx_d;
    hit_idx_q <= hit_idx_d;
    hit_cnt_q <= hit_cnt_d;
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o.selected        = sel_q;
    res_o.all_found       = (sel_cnt_q == target_q);
    res_o.table_full      = full_q;
    res_o.processed_count = query_q;
  end

endmodule
`default_nettype wire

// ----- design/event_key_match_selector.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// event_key_match_selector
// Keeps a table of wanted (run, lumi, event) keys and selects queries whose
// hit leaves the key's match count at one; a repeat of the last hit key adds none.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with operation_i (load or query),
// run_number_i, lumi_section_i and event_number_i. Each request gives one
// result on valid_o / stall_i: selected_o, all_found_o, table_full_o and
// processed_count_o.
// Keys live in a 128-bit RAM and match counts in a 2-bit RAM, both with a
// registered read port. A request scans the loaded entries, one RAM read per
// cycle, and stops at the first hit; then the match count is written back.
// One request is worked on at a time; in_stall_o is high while busy. The
// next request is taken at the earliest in the cycle after the result leaves the sequencer.
// The result sits in an output register, so the next request is taken while
// a result is still stalled; a new result waits in the sequencer until the
// output register frees up.
// Reset clears the fill level, all counters and the last hit key; the RAMs
// are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module event_key_match_selector import evkms_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        operation_i,
  input  wire logic [31:0] run_number_i,
  input  wire logic [31:0] lumi_section_i,
  input  wire logic [63:0] event_number_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic             selected_o,
  output logic             all_found_o,
  output logic             table_full_o,
  output logic [31:0]      processed_count_o
);

  evkms_mem_req_t     mem_req;
  logic [KEY_W-1:0]   key_rdata;
  logic [MATCH_W-1:0] cnt_rdata;
  logic               req_ready;
  logic               res_valid;
  logic               res_ready;
  evkms_res_t         res;
  logic               out_valid_q, out_valid_d;
  evkms_res_t         out_res_q;

  evkms_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .req_valid_i (in_valid_i),
    .req_ready_o (req_ready),
    .op_i        (operation_i),
    .key_i       ({run_number_i, lumi_section_i, event_number_i}),
    .mem_o       (mem_req),
    .key_rdata_i (key_rdata),
    .cnt_rdata_i (cnt_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  evkms_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk_i,
    .we_i    (mem_req.key_we),
    .waddr_i (mem_req.wr_addr),
    .wdata_i (mem_req.wr_key),
    .re_i    (mem_req.rd_en),
    .raddr_i (mem_req.rd_addr),
    .rdata_o (key_rdata)
  );

  evkms_ram #(
    .WIDTH (MATCH_W),
    .DEPTH (TABLE_DEPTH)
  ) u_cnt_ram (
    .clk_i,
    .we_i    (mem_req.cnt_we),
    .waddr_i (mem_req.wr_addr),
    .wdata_i (mem_req.wr_cnt),
    .re_i    (mem_req.rd_en),
    .raddr_i (mem_req.rd_addr),
    .rdata_o (cnt_rdata)
  );

  assign in_stall_o = !req_ready;
  assign res_ready  = !out_valid_q || !stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign valid_o           = out_valid_q;
  assign selected_o        = out_res_q.selected;
  assign all_found_o       = out_res_q.all_found;
  assign table_full_o      = out_res_q.table_full;
  assign processed_count_o = out_res_q.processed_count;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted request did not make the block busy");

  a_sel_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(selected_o && table_full_o))
    else $error("result is both selected and table full");

  a_sel_counts_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && selected_o |-> processed_count_o != 32'd0)
    else $error("selected result with zero processed count");
`endif

endmodule
`default_nettype wire
